// ----- rtl/lfr_pkg.sv -----
package lfr_pkg;

    // Request codes carried in the func field.
    localparam logic [1:0] FUNC_VICTIM = 2'd0;
    localparam logic [1:0] FUNC_PIN    = 2'd1;
    localparam logic [1:0] FUNC_UNPIN  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] frame_index;
    } t_req;

    typedef struct packed {
        logic       victim_found;
        logic [5:0] victim_frame;
        logic [6:0] list_count;
    } t_rsp;

endpackage

// ----- rtl/lfr_ram.sv -----
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // The read returns the contents from before a write at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lru_frame_replacer.sv -----
// Channel   Direction  Handshake                 Word
// request   in         i_in_valid / o_in_stall   i_in_word  (lfr_pkg::t_req)
// result    out        o_out_valid / i_out_stall o_out_word (lfr_pkg::t_rsp)
//
// One request is taken every cycle unless the request channel stalls; its result is
// presented at the next edge unless the result register is stalled. The list update is
// combinational from request to result register; link RAM reads are issued on acceptance.
// Reset (synchronous, i_rst_n low) empties the list at once; the link RAMs are not cleared.
// While the result register is full and stalled, the request register holds and the
// request channel stalls once it too is full.
module lru_frame_replacer #(
    parameter int FRAMES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lfr_pkg::t_req i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lfr_pkg::t_rsp o_out_word
);

    import lfr_pkg::*;

    localparam int AW = $clog2(FRAMES);
    localparam int LW = $clog2(FRAMES + 1);
    localparam logic [LW-1:0] NONE = LW'(FRAMES);

    logic          r_in_valid;
    t_req          r_in;
    logic          r_out_valid;
    t_rsp          r_out;
    t_rsp          n_out;

    logic [FRAMES-1:0] r_in_list, n_in_list;
    logic [LW-1:0]     r_head, n_head;
    logic [LW-1:0]     r_tail, n_tail;
    logic [LW-1:0]     r_count, n_count;

    logic          advance;
    logic          accept;
    logic [AW-1:0] req_addr;
    logic [AW-1:0] head_rd_addr;

    // Link RAM ports and same-edge write bypass.
    logic          prev_we, next_we;
    logic [AW-1:0] prev_wa, next_wa;
    logic [LW-1:0] prev_wd, next_wd;
    logic [LW-1:0] prev_q, next_q, headnxt_q;
    logic          r_pf_hit, r_nf_hit, r_hf_hit;
    logic [LW-1:0] r_pf_data, r_nf_data, r_hf_data;
    logic [LW-1:0] prev_rd, next_rd, headnxt_rd;

    logic [1:0]    func;
    logic [AW-1:0] fa;
    logic [LW-1:0] fl;
    logic          f_ok;
    logic          f_in;
    logic          do_victim, do_pin, do_unpin, do_unlink;
    logic [LW-1:0] u_node, u_prev, u_next;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign req_addr     = AW'(i_in_word.frame_index);
    assign head_rd_addr = n_head[AW-1:0];

    assign prev_rd    = r_pf_hit ? r_pf_data : prev_q;
    assign next_rd    = r_nf_hit ? r_nf_data : next_q;
    assign headnxt_rd = r_hf_hit ? r_hf_data : headnxt_q;

    lfr_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_wa),
        .i_wr_data (prev_wd),
        .i_rd_en   (accept),
        .i_rd_addr (req_addr),
        .o_rd_data (prev_q)
    );

    // Two copies of the next links: one read for the requested frame,
    // one kept pointed at the current head for victim requests.
    lfr_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_en   (accept),
        .i_rd_addr (req_addr),
        .o_rd_data (next_q)
    );

    lfr_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_en   (1'b1),
        .i_rd_addr (head_rd_addr),
        .o_rd_data (headnxt_q)
    );

    always_comb begin
        func = r_in.func;
        fa   = AW'(r_in.frame_index);
        fl   = LW'(fa);
        f_ok = 32'(r_in.frame_index) < 32'(FRAMES);
        f_in = r_in_list[fa];

        do_victim = advance && (func == FUNC_VICTIM) && (r_count != '0);
        do_pin    = advance && (func == FUNC_PIN) && f_ok && f_in;
        do_unpin  = advance && (func == FUNC_UNPIN) && f_ok && !f_in
                    && (r_count < LW'(FRAMES));
        do_unlink = do_victim || do_pin;

        // The new tail's next link is not written on append, so it is taken as none here.
        u_node = do_victim ? r_head : fl;
        u_prev = do_victim ? NONE : prev_rd;
        if (do_victim) begin
            u_next = (r_head == r_tail) ? NONE : headnxt_rd;
        end else begin
            u_next = (fl == r_tail) ? NONE : next_rd;
        end

        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_in_list = r_in_list;
        prev_we   = 1'b0;
        prev_wa   = '0;
        prev_wd   = '0;
        next_we   = 1'b0;
        next_wa   = '0;
        next_wd   = '0;

        if (do_unlink) begin
            if (u_prev != NONE) begin
                next_we = 1'b1;
                next_wa = u_prev[AW-1:0];
                next_wd = u_next;
            end else begin
                n_head = u_next;
            end
            if (u_next != NONE) begin
                prev_we = 1'b1;
                prev_wa = u_next[AW-1:0];
                prev_wd = u_prev;
            end else begin
                n_tail = u_prev;
            end
            n_in_list[u_node[AW-1:0]] = 1'b0;
            n_count = r_count - LW'(1);
        end else if (do_unpin) begin
            prev_we = 1'b1;
            prev_wa = fa;
            prev_wd = r_tail;
            if (r_tail != NONE) begin
                next_we = 1'b1;
                next_wa = r_tail[AW-1:0];
                next_wd = fl;
            end else begin
                n_head = fl;
            end
            n_tail        = fl;
            n_in_list[fa] = 1'b1;
            n_count       = r_count + LW'(1);
        end

        n_out.victim_found = do_victim;
        n_out.victim_frame = do_victim ? 6'(r_head) : 6'd0;
        n_out.list_count   = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_list   <= '0;
            r_head      <= NONE;
            r_tail      <= NONE;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_in_list <= n_in_list;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in      <= i_in_word;
            r_pf_hit  <= prev_we && (prev_wa == req_addr);
            r_pf_data <= prev_wd;
            r_nf_hit  <= next_we && (next_wa == req_addr);
            r_nf_data <= next_wd;
        end
        if (advance) begin
            r_out <= n_out;
        end
        r_hf_hit  <= next_we && (next_wa == head_rd_addr);
        r_hf_data <= next_wd;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(FRAMES))
        else $error("list length exceeds frame count");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == NONE))
        else $error("head disagrees with list length");

    a_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_tail == NONE))
        else $error("tail disagrees with list length");

    a_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_list) == int'(r_count))
        else $error("membership bits disagree with list length");

    a_victim_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_victim |=> !r_in_list[$past(r_head[AW-1:0])])
        else $error("evicted frame still marked present");
`endif

endmodule
